>>> hdl/llq_pkg.sv
// Shared opcodes, status codes and stream word layout for the linked-list queue
package llq_pkg;

  localparam int FIELD_W     = 16;
  localparam int OPCODE_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam int NOW_EMPTY_BIT = 2 * FIELD_W + STATUS_W;

endpackage

>>> hdl/llq_ram.sv
// Generic single-write, single-read RAM with registered read data
module llq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/linked_list_queue_free_list_core.sv
// Coordinate-pair FIFO held as a linked list in a node store, with a free list
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+---------------------------------------
//   in_      | in  | tvalid / tready  | opcode, item_first, item_second
//   out_     | out | tvalid / tready  | out_first, out_second, status, now_empty
//
// One word per cycle: each word is executed in the cycle it is accepted, the
// result word is registered. Head pair, head link and free link come from
// RAMs read in the previous cycle at the next-state pointers, with a one-deep
// write bypass. Free nodes never yet handed out are tracked by a fill count,
// so reset needs no clearing pass. in_tready drops only while the result
// register holds a word that out_tready does not take.
module linked_list_queue_free_list_core #(
  parameter int QUEUE_DEPTH = 128,
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [1:0] opcode, [17:2] item_first, [33:18] item_second, [39:34] zero
  input  logic [llq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] out_first, [31:16] out_second, [33:32] status, [34] now_empty
  output logic [llq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import llq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int PW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(QUEUE_DEPTH);

  function automatic logic [COORD_WIDTH-1:0] to_store(input logic [FIELD_W-1:0] v);
    logic [XW-1:0] e;
    e = XW'(v);
    return e[COORD_WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_out(input logic [COORD_WIDTH-1:0] s);
    logic signed [XW-1:0] e;
    e = XW'($signed(s));
    return e[FIELD_W-1:0];
  endfunction

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] free_r, free_nxt;
  logic [PW-1:0] fresh_r, fresh_nxt;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                     pbyp_valid_r;
  logic [AW-1:0]            pbyp_addr_r;
  logic [2*COORD_WIDTH-1:0] pbyp_data_r;
  logic                     lbyp_valid_r;
  logic [AW-1:0]            lbyp_addr_r;
  logic [PW-1:0]            lbyp_data_r;

  logic                     pair_we;
  logic [2*COORD_WIDTH-1:0] pair_wdata;
  logic [2*COORD_WIDTH-1:0] pair_rdata;
  logic                     link_we;
  logic [AW-1:0]            link_waddr;
  logic [PW-1:0]            link_wdata;
  logic [PW-1:0]            hlink_rdata;
  logic [PW-1:0]            flink_rdata;

  logic [2*COORD_WIDTH-1:0] head_pair;
  logic [PW-1:0]            head_link;
  logic [PW-1:0]            free_link;

  logic                exec;
  logic [OPCODE_W-1:0] opcode;
  logic [FIELD_W-1:0]  item_first;
  logic [FIELD_W-1:0]  item_second;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  res_first;
  logic [FIELD_W-1:0]  res_second;
  logic                now_empty;

  assign opcode      = in_tdata[OPCODE_W-1:0];
  assign item_first  = in_tdata[OPCODE_W +: FIELD_W];
  assign item_second = in_tdata[OPCODE_W+FIELD_W +: FIELD_W];

  assign in_tready = !out_valid_r || out_tready;
  assign exec      = in_tvalid && in_tready;

  assign head_pair = (pbyp_valid_r && pbyp_addr_r == head_r[AW-1:0]) ? pbyp_data_r
                                                                    : pair_rdata;
  assign head_link = (lbyp_valid_r && lbyp_addr_r == head_r[AW-1:0]) ? lbyp_data_r
                                                                    : hlink_rdata;
  always_comb begin
    if (free_r == fresh_r) begin
      free_link = PW'(free_r + 1'b1);
    end else if (lbyp_valid_r && lbyp_addr_r == free_r[AW-1:0]) begin
      free_link = lbyp_data_r;
    end else begin
      free_link = flink_rdata;
    end
  end

  assign pair_wdata = {to_store(item_second), to_store(item_first)};

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    free_nxt   = free_r;
    fresh_nxt  = fresh_r;
    pair_we    = 1'b0;
    link_we    = 1'b0;
    link_waddr = tail_r[AW-1:0];
    link_wdata = free_r;
    status     = ST_OK;
    res_first  = '0;
    res_second = '0;
    if (exec) begin
      case (opcode)
        OP_PUSH: begin
          if (free_r == NULL_PTR) begin
            status = ST_FULL;
          end else begin
            pair_we  = 1'b1;
            free_nxt = free_link;
            if (free_r == fresh_r) begin
              fresh_nxt = PW'(fresh_r + 1'b1);
            end
            if (head_r == NULL_PTR) begin
              head_nxt = free_r;
            end else begin
              link_we    = 1'b1;
              link_waddr = tail_r[AW-1:0];
              link_wdata = free_r;
            end
            tail_nxt = free_r;
          end
        end
        OP_POP, OP_PEEK: begin
          if (head_r == NULL_PTR) begin
            status = ST_EMPTY;
          end else begin
            res_first  = to_out(head_pair[COORD_WIDTH-1:0]);
            res_second = to_out(head_pair[2*COORD_WIDTH-1:COORD_WIDTH]);
            if (opcode == OP_POP) begin
              if (head_r == tail_r) begin
                head_nxt = NULL_PTR;
                tail_nxt = NULL_PTR;
              end else begin
                head_nxt = head_link;
              end
              link_we    = 1'b1;
              link_waddr = head_r[AW-1:0];
              link_wdata = free_r;
              free_nxt   = head_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign now_empty = (head_nxt == NULL_PTR);

  llq_ram #(.WIDTH(2 * COORD_WIDTH), .DEPTH(QUEUE_DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (free_r[AW-1:0]),
    .wdata (pair_wdata),
    .raddr (head_nxt[AW-1:0]),
    .rdata (pair_rdata)
  );

  llq_ram #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH)) u_hlink_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (head_nxt[AW-1:0]),
    .rdata (hlink_rdata)
  );

  llq_ram #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH)) u_flink_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (free_nxt[AW-1:0]),
    .rdata (flink_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= NULL_PTR;
      tail_r       <= NULL_PTR;
      free_r       <= '0;
      fresh_r      <= '0;
      out_valid_r  <= 1'b0;
      pbyp_valid_r <= 1'b0;
      lbyp_valid_r <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      free_r       <= free_nxt;
      fresh_r      <= fresh_nxt;
      pbyp_valid_r <= pair_we;
      lbyp_valid_r <= link_we;
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pbyp_addr_r <= free_r[AW-1:0];
    pbyp_data_r <= pair_wdata;
    lbyp_addr_r <= link_waddr;
    lbyp_data_r <= link_wdata;
    if (exec) begin
      out_data_r <= OUT_TDATA_W'({now_empty, status, res_second, res_first});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_head_tail_null: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NULL_PTR) == (tail_r == NULL_PTR))
    else $error("head and tail disagree on an empty queue");

  a_free_below_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r < fresh_r) || (free_r == fresh_r))
    else $error("free head beyond the fill count");

  a_full_all_used: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r == NULL_PTR) |-> (fresh_r == NULL_PTR))
    else $error("free list exhausted before every node was handed out");

  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && opcode == OP_PUSH && free_r != NULL_PTR)
      |=> (out_valid_r && !out_data_r[NOW_EMPTY_BIT]))
    else $error("accepted push reported an empty queue");

  a_pop_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && opcode == OP_POP && head_r == NULL_PTR)
      |=> (out_data_r[2*FIELD_W +: STATUS_W] == ST_EMPTY))
    else $error("pop on an empty queue without empty status");
`endif

endmodule
